/* rtl/tsrd_pkg.sv */
// Shared widths, register indexes and pipeline control type for the slot role decoder.
`default_nettype none

package tsrd_pkg;

    localparam int MAX_HOPS_DEF = 8;

    localparam int SEQ_W     = 16;
    localparam int GTS_W     = 8;
    localparam int G_W       = 9;
    localparam int CNT_W     = 5;
    localparam int CL_W      = 4;
    localparam int MAP_W     = 16;
    localparam int HOP_W     = 4;
    localparam int HOP_SEL_W = 3;
    localparam int TBL_W     = 64;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int POS_W     = 15;
    localparam int GRP_W     = 12;
    localparam int REM_A_W   = 12;
    localparam int REM_B_W   = 10;
    localparam int PSUM_W    = 10;
    localparam int QHI_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_GTS_PER_CLUSTER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_CLUSTER     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COORD_CLUSTER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BEACON_MAP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOP_COUNT       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INTER_GTS_TABLE = 3'd6;

    typedef struct packed {
        logic ld_a;
        logic ld_b;
        logic ld_c;
    } tsrd_ctl_t;

endpackage

`default_nettype wire

/* rtl/tsrd_pipe_ctl.sv */
// Valid bits and per-stage load enables of the three-stage decoder pipeline.
`default_nettype none

module tsrd_pipe_ctl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output tsrd_pkg::tsrd_ctl_t    ctl
);
    import tsrd_pkg::*;

    logic v_a_reg, v_b_reg, v_c_reg;
    logic v_a_next, v_b_next, v_c_next;
    logic rdy_a, rdy_b, rdy_c;

    always_comb begin
        rdy_c    = !v_c_reg || m_ready;
        rdy_b    = !v_b_reg || rdy_c;
        rdy_a    = !v_a_reg || rdy_b;
        v_a_next = rdy_a ? s_valid : v_a_reg;
        v_b_next = rdy_b ? v_a_reg : v_b_reg;
        v_c_next = rdy_c ? v_b_reg : v_c_reg;
        ctl.ld_a = rdy_a;
        ctl.ld_b = rdy_b;
        ctl.ld_c = rdy_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
        end else begin
            v_a_reg <= v_a_next;
            v_b_reg <= v_b_next;
            v_c_reg <= v_c_next;
        end
    end

    assign s_ready = rdy_a;
    assign m_valid = v_c_reg;

endmodule

`default_nettype wire

/* rtl/tsrd_group_div.sv */
// Restoring division of the slot number by the group length, upper quotient bits.
`default_nettype none

module tsrd_group_div (
    input  wire logic                           aclk,
    input  wire tsrd_pkg::tsrd_ctl_t            ctl,
    input  wire logic [tsrd_pkg::GTS_W-1:0]     gts_per_cluster,
    input  wire logic [tsrd_pkg::SEQ_W-1:0]     slot_seq,
    output logic                                grp_ovf_b,
    output logic [tsrd_pkg::QHI_W-1:0]          q_hi_b,
    output logic [tsrd_pkg::REM_B_W-1:0]        rem_b
);
    import tsrd_pkg::*;

    logic [G_W-1:0]     g;
    logic [SEQ_W-1:0]   g_x16, g_x8, rem_s;
    logic [REM_A_W-1:0] g_x4;
    logic [REM_A_W-1:0] rem2;
    logic [G_W:0]       g_x2;
    logic [G_W+1:0]     rem3;

    logic               ovf_a_reg, ovf_a_next;
    logic               q3_a_reg, q3_a_next;
    logic [REM_A_W-1:0] rem_a_reg, rem_a_next;

    logic               ovf_b_reg, ovf_b_next;
    logic [QHI_W-1:0]   q_b_reg, q_b_next;
    logic [REM_B_W-1:0] rem_b_reg, rem_b_next;

    logic q2, q1;

    always_comb begin
        g          = G_W'(gts_per_cluster) + G_W'(1);
        g_x16      = {3'b000, g, 4'b0000};
        g_x8       = {4'b0000, g, 3'b000};
        ovf_a_next = slot_seq >= g_x16;
        q3_a_next  = slot_seq >= g_x8;
        rem_s      = q3_a_next ? (slot_seq - g_x8) : slot_seq;
        rem_a_next = rem_s[REM_A_W-1:0];
    end

    always_comb begin
        g_x4       = {1'b0, g, 2'b00};
        q2         = rem_a_reg >= g_x4;
        rem2       = q2 ? (rem_a_reg - g_x4) : rem_a_reg;
        g_x2       = {g, 1'b0};
        q1         = rem2[G_W+1:0] >= {1'b0, g_x2};
        rem3       = q1 ? (rem2[G_W+1:0] - {1'b0, g_x2}) : rem2[G_W+1:0];
        ovf_b_next = ovf_a_reg;
        q_b_next   = {q3_a_reg, q2, q1};
        rem_b_next = rem3[REM_B_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld_a) begin
            ovf_a_reg <= ovf_a_next;
            q3_a_reg  <= q3_a_next;
            rem_a_reg <= rem_a_next;
        end
        if (ctl.ld_b) begin
            ovf_b_reg <= ovf_b_next;
            q_b_reg   <= q_b_next;
            rem_b_reg <= rem_b_next;
        end
    end

    assign grp_ovf_b = ovf_b_reg;
    assign q_hi_b    = q_b_reg;
    assign rem_b     = rem_b_reg;

endmodule

`default_nettype wire

/* rtl/tsrd_hop_window.sv */
// Start and length of one hop's inter-GTS window and the slot hit test against it.
`default_nettype none

module tsrd_hop_window #(
    parameter int MAX_HOPS = tsrd_pkg::MAX_HOPS_DEF
) (
    input  wire logic                           aclk,
    input  wire tsrd_pkg::tsrd_ctl_t            ctl,
    input  wire logic                           hop_en,
    input  wire logic [tsrd_pkg::HOP_W-1:0]     hop_idx,
    input  wire logic [tsrd_pkg::TBL_W-1:0]     gts_table,
    input  wire logic [tsrd_pkg::POS_W-1:0]     base_a,
    input  wire logic [tsrd_pkg::SEQ_W-1:0]     seq_b,
    output logic                                hit
);
    import tsrd_pkg::*;

    logic [PSUM_W-1:0] lo_a_next, hi_a_next;
    logic [BYTE_W-1:0] len_a_next;

    logic [PSUM_W-1:0] lo_a_reg, hi_a_reg;
    logic [BYTE_W-1:0] len_a_reg;
    logic              ok_a_reg;

    logic [POS_W-1:0]  start_b_reg, start_b_next;
    logic [BYTE_W-1:0] len_b_reg;
    logic              ok_b_reg;

    logic [SEQ_W-1:0]  win_lo, win_hi;

    always_comb begin
        lo_a_next = '0;
        hi_a_next = '0;
        for (int k = 0; k < 4; k++) begin
            if (k < MAX_HOPS && HOP_W'(k) < hop_idx) begin
                lo_a_next = lo_a_next + PSUM_W'(gts_table[k*BYTE_W +: BYTE_W]);
            end
        end
        for (int k = 4; k < 8; k++) begin
            if (k < MAX_HOPS && HOP_W'(k) < hop_idx) begin
                hi_a_next = hi_a_next + PSUM_W'(gts_table[k*BYTE_W +: BYTE_W]);
            end
        end
        if (hop_idx < HOP_W'(MAX_HOPS)) begin
            len_a_next = gts_table[{hop_idx[HOP_SEL_W-1:0], 3'b000} +: BYTE_W];
        end else begin
            len_a_next = '0;
        end
    end

    assign start_b_next = base_a + POS_W'(lo_a_reg) + POS_W'(hi_a_reg);

    always_ff @(posedge aclk) begin
        if (ctl.ld_a) begin
            lo_a_reg  <= lo_a_next;
            hi_a_reg  <= hi_a_next;
            len_a_reg <= len_a_next;
            ok_a_reg  <= hop_en;
        end
        if (ctl.ld_b) begin
            start_b_reg <= start_b_next;
            len_b_reg   <= len_a_reg;
            ok_b_reg    <= ok_a_reg;
        end
    end

    always_comb begin
        win_lo = {1'b0, start_b_reg};
        win_hi = win_lo + SEQ_W'(len_b_reg);
        hit    = ok_b_reg && (seq_b >= win_lo) && (seq_b < win_hi);
    end

endmodule

`default_nettype wire

/* rtl/tdma_slot_role_decoder.sv */
// Path: stage A registers, then stage B registers, then the output register.
// Throughput: one slot word per cycle; a stalled result holds the output register
// while bubbles in the three stages still take new words.
// Stages: group compare and first quotient bit, two quotient bits and window starts,
// last quotient bit and role flags into the output register.
// Reset: clears the valid bits and all configuration registers to zero.
`default_nettype none

module tdma_slot_role_decoder #(
    parameter int MAX_HOPS = tsrd_pkg::MAX_HOPS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [tsrd_pkg::SEQ_W-1:0]         s_slot_seq,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_beacon_rx,
    output logic                                    m_coord_beacon_rx,
    output logic                                    m_own_beacon_tx,
    output logic                                    m_own_intra_gts,
    output logic                                    m_coord_intra_gts,
    output logic                                    m_parent_inter_gts,
    output logic                                    m_own_inter_gts,
    output logic                                    m_index_overflow,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tsrd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tsrd_pkg::TBL_W-1:0]         cfg_data
);
    import tsrd_pkg::*;

    logic [GTS_W-1:0] gts_per_cluster_reg;
    logic [CNT_W-1:0] cluster_count_reg;
    logic [CL_W-1:0]  own_cluster_reg;
    logic [CL_W-1:0]  coord_cluster_reg;
    logic [MAP_W-1:0] beacon_map_reg;
    logic [HOP_W-1:0] hop_count_reg;
    logic [TBL_W-1:0] inter_gts_table_reg;

    tsrd_ctl_t ctl;

    logic [G_W-1:0]   g;
    logic [SEQ_W-1:0] seq_a_reg, seq_b_reg;
    logic [GRP_W-1:0] own_lo_a_reg, own_lo_a_next, coord_lo_a_reg, coord_lo_a_next;
    logic [GRP_W-1:0] own_lo_b_reg, coord_lo_b_reg;
    logic [POS_W-1:0] base_a_reg, base_a_next;

    logic               grp_ovf_b;
    logic [QHI_W-1:0]   q_hi_b;
    logic [REM_B_W-1:0] rem_b;

    logic             own_hop_en, parent_hop_en;
    logic [HOP_W-1:0] parent_hop;
    logic             own_hit, parent_hit;

    logic             q0;
    logic [CL_W-1:0]  grp_n;
    logic             hop_ovf;
    logic [SEQ_W-1:0] own_lo_x, own_hi_x, coord_lo_x, coord_hi_x;

    logic beacon_rx_next, coord_beacon_rx_next, own_beacon_tx_next, own_intra_gts_next;
    logic coord_intra_gts_next, parent_inter_gts_next, own_inter_gts_next;
    logic index_overflow_next;

    logic beacon_rx_reg, coord_beacon_rx_reg, own_beacon_tx_reg, own_intra_gts_reg;
    logic coord_intra_gts_reg, parent_inter_gts_reg, own_inter_gts_reg;
    logic index_overflow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gts_per_cluster_reg <= '0;
            cluster_count_reg   <= '0;
            own_cluster_reg     <= '0;
            coord_cluster_reg   <= '0;
            beacon_map_reg      <= '0;
            hop_count_reg       <= '0;
            inter_gts_table_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_GTS_PER_CLUSTER: gts_per_cluster_reg <= cfg_data[GTS_W-1:0];
                REG_CLUSTER_COUNT:   cluster_count_reg   <= cfg_data[CNT_W-1:0];
                REG_OWN_CLUSTER:     own_cluster_reg     <= cfg_data[CL_W-1:0];
                REG_COORD_CLUSTER:   coord_cluster_reg   <= cfg_data[CL_W-1:0];
                REG_BEACON_MAP:      beacon_map_reg      <= cfg_data[MAP_W-1:0];
                REG_HOP_COUNT:       hop_count_reg       <= cfg_data[HOP_W-1:0];
                REG_INTER_GTS_TABLE: inter_gts_table_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    tsrd_pipe_ctl u_ctl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    tsrd_group_div u_div (
        .aclk            (aclk),
        .ctl             (ctl),
        .gts_per_cluster (gts_per_cluster_reg),
        .slot_seq        (s_slot_seq),
        .grp_ovf_b       (grp_ovf_b),
        .q_hi_b          (q_hi_b),
        .rem_b           (rem_b)
    );

    always_comb begin
        g               = G_W'(gts_per_cluster_reg) + G_W'(1);
        own_lo_a_next   = GRP_W'(own_cluster_reg) * GRP_W'(g);
        coord_lo_a_next = GRP_W'(coord_cluster_reg) * GRP_W'(g);
        base_a_next     = POS_W'(g) * POS_W'(cluster_count_reg);
        hop_ovf         = hop_count_reg >= HOP_W'(MAX_HOPS);
        own_hop_en      = !hop_ovf;
        parent_hop      = hop_count_reg - HOP_W'(1);
        parent_hop_en   = (hop_count_reg != '0) && (parent_hop < HOP_W'(MAX_HOPS));
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld_a) begin
            seq_a_reg      <= s_slot_seq;
            own_lo_a_reg   <= own_lo_a_next;
            coord_lo_a_reg <= coord_lo_a_next;
            base_a_reg     <= base_a_next;
        end
        if (ctl.ld_b) begin
            seq_b_reg      <= seq_a_reg;
            own_lo_b_reg   <= own_lo_a_reg;
            coord_lo_b_reg <= coord_lo_a_reg;
        end
    end

    tsrd_hop_window #(
        .MAX_HOPS (MAX_HOPS)
    ) u_own_win (
        .aclk      (aclk),
        .ctl       (ctl),
        .hop_en    (own_hop_en),
        .hop_idx   (hop_count_reg),
        .gts_table (inter_gts_table_reg),
        .base_a    (base_a_reg),
        .seq_b     (seq_b_reg),
        .hit       (own_hit)
    );

    tsrd_hop_window #(
        .MAX_HOPS (MAX_HOPS)
    ) u_parent_win (
        .aclk      (aclk),
        .ctl       (ctl),
        .hop_en    (parent_hop_en),
        .hop_idx   (parent_hop),
        .gts_table (inter_gts_table_reg),
        .base_a    (base_a_reg),
        .seq_b     (seq_b_reg),
        .hit       (parent_hit)
    );

    always_comb begin
        q0     = rem_b >= {1'b0, g};
        grp_n  = {q_hi_b, q0};
        own_lo_x   = SEQ_W'(own_lo_b_reg);
        own_hi_x   = own_lo_x + SEQ_W'(g);
        coord_lo_x = SEQ_W'(coord_lo_b_reg);
        coord_hi_x = coord_lo_x + SEQ_W'(g);

        beacon_rx_next        = !grp_ovf_b && beacon_map_reg[grp_n];
        coord_beacon_rx_next  = !grp_ovf_b && (grp_n == coord_cluster_reg);
        own_beacon_tx_next    = !grp_ovf_b && (grp_n == own_cluster_reg);
        own_intra_gts_next    = (seq_b_reg > own_lo_x) && (seq_b_reg < own_hi_x);
        coord_intra_gts_next  = (seq_b_reg > coord_lo_x) && (seq_b_reg < coord_hi_x);
        parent_inter_gts_next = parent_hit;
        own_inter_gts_next    = own_hit;
        index_overflow_next   = grp_ovf_b || hop_ovf;
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld_c) begin
            beacon_rx_reg        <= beacon_rx_next;
            coord_beacon_rx_reg  <= coord_beacon_rx_next;
            own_beacon_tx_reg    <= own_beacon_tx_next;
            own_intra_gts_reg    <= own_intra_gts_next;
            coord_intra_gts_reg  <= coord_intra_gts_next;
            parent_inter_gts_reg <= parent_inter_gts_next;
            own_inter_gts_reg    <= own_inter_gts_next;
            index_overflow_reg   <= index_overflow_next;
        end
    end

    assign m_beacon_rx        = beacon_rx_reg;
    assign m_coord_beacon_rx  = coord_beacon_rx_reg;
    assign m_own_beacon_tx    = own_beacon_tx_reg;
    assign m_own_intra_gts    = own_intra_gts_reg;
    assign m_coord_intra_gts  = coord_intra_gts_reg;
    assign m_parent_inter_gts = parent_inter_gts_reg;
    assign m_own_inter_gts    = own_inter_gts_reg;
    assign m_index_overflow   = index_overflow_reg;

`ifndef SYNTHESIS
    a_own_gts_in_group: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_own_intra_gts |-> m_own_beacon_tx)
        else $error("own intra GTS outside own group");

    a_coord_gts_in_group: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_coord_intra_gts |-> m_coord_beacon_rx)
        else $error("coordinator intra GTS outside coordinator group");

    a_windows_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_own_inter_gts && m_parent_inter_gts))
        else $error("own and parent inter GTS windows overlap");

    a_same_group: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_own_beacon_tx && m_coord_beacon_rx |->
        own_cluster_reg == coord_cluster_reg)
        else $error("group matches two different clusters");
`endif

endmodule

`default_nettype wire
